/* hdl/sgm_pkg.sv */
// Shared types and constants for the sample gap monitor.
package sgm_pkg;

	localparam int unsigned PERIOD_W = 20;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd9615;
	localparam int unsigned DROP_NUM = 18;
	localparam int unsigned DROP_DEN = 10;
	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUB,
		ST_SCALE,
		ST_TEST,
		ST_DIV,
		ST_ACC,
		ST_COMMIT,
		ST_HOLD
	} sgm_state_t;

	typedef struct packed {
		logic capture;
		logic sub;
		logic scale;
		logic test;
		logic div_step;
		logic acc;
		logic commit;
		logic load_out;
	} sgm_cmd_t;

	typedef struct packed {
		logic drop_due;
		logic div_last;
	} sgm_sts_t;

endpackage

/* hdl/sgm_ctrl.sv */
// Sequencer for the sample gap monitor: state machine and output handshake.
module sgm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  sgm_pkg::sgm_sts_t sts,
	output sgm_pkg::sgm_cmd_t cmd
);

	sgm_pkg::sgm_state_t state_q, state_d;
	logic                out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sgm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			sgm_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = sgm_pkg::ST_SUB;
				end
			end
			sgm_pkg::ST_SUB: begin
				cmd.sub = 1'b1;
				state_d = sgm_pkg::ST_SCALE;
			end
			sgm_pkg::ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = sgm_pkg::ST_TEST;
			end
			sgm_pkg::ST_TEST: begin
				cmd.test = 1'b1;
				state_d  = sts.drop_due ? sgm_pkg::ST_DIV : sgm_pkg::ST_COMMIT;
			end
			sgm_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = sgm_pkg::ST_ACC;
				end
			end
			sgm_pkg::ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = sgm_pkg::ST_COMMIT;
			end
			sgm_pkg::ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = sgm_pkg::ST_HOLD;
			end
			sgm_pkg::ST_HOLD: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = sgm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sgm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* hdl/sgm_dp.sv */
// Datapath for the sample gap monitor: statistics registers, threshold test, serial divider.
module sgm_dp #(
	parameter int unsigned TIME_WIDTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [sgm_pkg::PERIOD_W-1:0] cfg_wdata,
	input  logic [63:0]                  sample_time,
	input  sgm_pkg::sgm_cmd_t            cmd,
	output sgm_pkg::sgm_sts_t            sts,
	output logic [31:0]                  sample_count,
	output logic [63:0]                  start_time_us,
	output logic [31:0]                  gap_us,
	output logic [31:0]                  largest_gap_us,
	output logic [31:0]                  dropped_estimate,
	output logic                         went_backwards
);

	localparam int unsigned PW  = sgm_pkg::PERIOD_W;
	localparam int unsigned GW  = TIME_WIDTH + 4;
	localparam int unsigned SW  = PW + 5;
	localparam int unsigned CW  = $clog2(TIME_WIDTH);

	logic [PW-1:0]         period_q;
	logic [31:0]           count_q;
	logic [TIME_WIDTH-1:0] first_q;
	logic [TIME_WIDTH-1:0] prev_q;
	logic [31:0]           recent_q;
	logic [31:0]           peak_q;
	logic [31:0]           missed_q;
	logic                  back_flag_q;

	logic [TIME_WIDTH-1:0] t_q;
	logic [TIME_WIDTH-1:0] gap_q;
	logic                  lt_q;
	logic [GW-1:0]         gap10_q;
	logic [SW-1:0]         per18_q;

	logic [TIME_WIDTH-1:0] quo_q;
	logic [PW-1:0]         rem_q;
	logic [CW-1:0]         cnt_q;

	logic [31:0]           cnt_out_q;
	logic [TIME_WIDTH-1:0] first_out_q;
	logic [31:0]           recent_out_q;
	logic [31:0]           peak_out_q;
	logic [31:0]           missed_out_q;
	logic                  back_out_q;

	logic [63:0]           gap_ext;
	logic [31:0]           gap_sat;
	logic                  count_zero;
	logic [PW:0]           rem_sh;
	logic [PW:0]           rem_diff;
	logic                  q_bit;
	logic [63:0]           add_ext;
	logic [31:0]           add_sat;
	logic [32:0]           sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= sgm_pkg::PERIOD_RESET;
		end else if (cfg_wr_en) begin
			period_q <= cfg_wdata;
		end
	end

	assign gap_ext    = 64'(gap_q);
	assign gap_sat    = (|gap_ext[63:32]) ? sgm_pkg::SAT32 : gap_ext[31:0];
	assign count_zero = (count_q == 32'd0);

	assign sts.drop_due = !count_zero && !lt_q && (period_q != '0)
		&& (gap10_q > GW'(per18_q));
	assign sts.div_last = (cnt_q == CW'(TIME_WIDTH - 1));

	assign rem_sh   = {rem_q, quo_q[TIME_WIDTH-1]};
	assign rem_diff = rem_sh - {1'b0, period_q};
	assign q_bit    = (rem_sh >= {1'b0, period_q});

	assign add_ext = 64'(quo_q) - 64'd1;
	assign add_sat = (|add_ext[63:32]) ? sgm_pkg::SAT32 : add_ext[31:0];
	assign sum     = {1'b0, missed_q} + {1'b0, add_sat};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			t_q <= sample_time[TIME_WIDTH-1:0];
		end
		if (cmd.sub) begin
			gap_q <= t_q - prev_q;
			lt_q  <= (t_q < prev_q);
		end
		if (cmd.scale) begin
			gap10_q <= GW'(gap_q) * GW'(sgm_pkg::DROP_DEN);
			per18_q <= SW'(period_q) * SW'(sgm_pkg::DROP_NUM);
		end
		if (cmd.test) begin
			quo_q <= gap_q;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[TIME_WIDTH-2:0], q_bit};
			rem_q <= q_bit ? rem_diff[PW-1:0] : rem_sh[PW-1:0];
			cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			first_q     <= '0;
			prev_q      <= '0;
			recent_q    <= '0;
			peak_q      <= '0;
			missed_q    <= '0;
			back_flag_q <= 1'b0;
		end else begin
			if (cmd.test) begin
				priority if (count_zero) begin
					first_q <= t_q;
				end else if (lt_q) begin
					back_flag_q <= 1'b1;
				end else begin
					recent_q <= gap_sat;
					if (gap_sat > peak_q) begin
						peak_q <= gap_sat;
					end
				end
			end
			if (cmd.acc) begin
				missed_q <= sum[32] ? sgm_pkg::SAT32 : sum[31:0];
			end
			if (cmd.commit) begin
				prev_q <= t_q;
				if (count_q != sgm_pkg::SAT32) begin
					count_q <= count_q + 32'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			cnt_out_q    <= count_q;
			first_out_q  <= first_q;
			recent_out_q <= recent_q;
			peak_out_q   <= peak_q;
			missed_out_q <= missed_q;
			back_out_q   <= back_flag_q;
		end
	end

	assign sample_count     = cnt_out_q;
	assign start_time_us    = 64'(first_out_q);
	assign gap_us           = recent_out_q;
	assign largest_gap_us   = peak_out_q;
	assign dropped_estimate = missed_out_q;
	assign went_backwards   = back_out_q;

endmodule

/* hdl/sample_gap_monitor.sv */
// Top level of the sample gap monitor: sequencer plus datapath.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------------
//  input    | in_valid / in_ready    | sample_time
//  output   | out_valid / out_ready  | sample_count, start_time_us, gap_us,
//           |                        | largest_gap_us, dropped_estimate, went_backwards
//  config   | cfg_wr_en              | cfg_wdata (nominal period)
//
// An item goes through SUB, SCALE, TEST, COMMIT and HOLD to the result register, with
// DIV and ACC between TEST and COMMIT when the dropped-sample estimate is updated; the
// serial restoring divider of the gap by the period yields one quotient bit a cycle.
// One item is in work at a time; in_ready returns while a finished result waits.
// A stalled output holds its result; the next result waits until it is taken.
// Reset clears all statistics and loads the period with 9615.
module sample_gap_monitor #(
	parameter int unsigned TIME_WIDTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [sgm_pkg::PERIOD_W-1:0] cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [63:0]                  sample_time,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [31:0]                  sample_count,
	output logic [63:0]                  start_time_us,
	output logic [31:0]                  gap_us,
	output logic [31:0]                  largest_gap_us,
	output logic [31:0]                  dropped_estimate,
	output logic                         went_backwards
);

	sgm_pkg::sgm_cmd_t cmd;
	sgm_pkg::sgm_sts_t sts;

	sgm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sgm_dp #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wdata        (cfg_wdata),
		.sample_time      (sample_time),
		.cmd              (cmd),
		.sts              (sts),
		.sample_count     (sample_count),
		.start_time_us    (start_time_us),
		.gap_us           (gap_us),
		.largest_gap_us   (largest_gap_us),
		.dropped_estimate (dropped_estimate),
		.went_backwards   (went_backwards)
	);

endmodule

/* hdl/sgm_checker.sv */
// Port-level checks for the sample gap monitor, bound to the top level.
module sgm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] sample_count,
	input logic [31:0] gap_us,
	input logic [31:0] largest_gap_us,
	input logic        went_backwards
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_count)
		&& $stable(went_backwards))
		else $error("stalled result changed");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sample_count != 32'd0)
		else $error("result shows zero samples");

	a_peak_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> largest_gap_us >= gap_us)
		else $error("largest gap below last gap");

	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in work");

endmodule

bind sample_gap_monitor sgm_checker u_sgm_checker (.*);
